// File: rtl/b32e_pkg.sv
`timescale 1ns / 1ps

package b32e_pkg;

  // Dash that separates groups of five symbols.
  localparam logic [6:0] DASH_CHAR = 7'h2D;
  localparam logic [2:0] GROUP_LAST = 3'd4;
  localparam logic [3:0] SYM_BITS = 4'd5;
  localparam int unsigned MAX_RESULTS = 4;

  // Encoder state carried from one byte to the next.
  typedef struct packed {
    logic [3:0] bits;
    logic [2:0] cnt;
    logic [2:0] grp;
    logic       any;
  } b32e_state_t;

  // One output character with its end marker.
  typedef struct packed {
    logic [6:0] ch;
    logic       eom;
  } b32e_entry_t;

  // All characters produced by one byte; last is the index of the final one.
  typedef struct packed {
    b32e_entry_t [MAX_RESULTS-1:0] ent;
    logic [1:0]                    last;
  } b32e_burst_t;

  // Alphabet A-Z then 2-7: letters start at 0x41, digits at 0x32 for code 26.
  function automatic logic [6:0] sym_ascii(input logic [4:0] sym);
    logic [6:0] res;
    if (sym < 5'd26) begin
      res = 7'h41 + {2'b00, sym};
    end else begin
      res = 7'h18 + {2'b00, sym};
    end
    return res;
  endfunction

endpackage

// File: rtl/b32e_byte_if.sv
`timescale 1ns / 1ps

interface b32e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_final;

  modport source (output valid, output data_byte, output is_final, input ready);
  modport sink (input valid, input data_byte, input is_final, output ready);
endinterface

// File: rtl/b32e_char_if.sv
`timescale 1ns / 1ps

interface b32e_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       end_of_message;

  modport source (output valid, output out_char, output end_of_message, input ready);
  modport sink (input valid, input out_char, input end_of_message, output ready);
endinterface

// File: rtl/base32_encoder_grouped.sv
`timescale 1ns / 1ps
// The first character of a byte appears once the byte has passed the input and burst registers.
// A byte yields one to four characters, one per cycle on the output while out_ch.ready is high,
// and the next byte is taken while the current burst drains.
// The output burst register and its read pointer set the rate.
// Reset (synchronous, active low) clears the encoder state and both stage valids.

module base32_encoder_grouped
  import b32e_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  b32e_byte_if.sink   in_ch,
  b32e_char_if.source out_ch
);

  // Input register: holds the raw byte of one accepted transaction.
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_fin_r;

  // Burst register: every character produced by one byte, drained in order.
  logic        s2_valid_r;
  b32e_burst_t s2_burst_r;
  logic [1:0]  s2_ptr_r;

  // Encoder state is advanced when a byte moves from the input register
  // into the burst register, so the next byte always sees up-to-date state.
  b32e_state_t st_r;
  b32e_state_t st_nxt;
  b32e_burst_t burst_nxt;

  logic out_take;
  logic s2_done;
  logic s2_load;

  b32e_expand u_expand (
    .state_i (st_r),
    .byte_i  (s1_byte_r),
    .fin_i   (s1_fin_r),
    .burst_o (burst_nxt),
    .state_o (st_nxt)
  );

  assign out_take = s2_valid_r && out_ch.ready;
  assign s2_done  = out_take && (s2_ptr_r == s2_burst_r.last);
  // The burst register is refilled in the same cycle its last character leaves.
  assign s2_load  = s1_valid_r && (!s2_valid_r || s2_done);

  // A new byte enters whenever the input register is free or is moving on.
  assign in_ch.ready = !s1_valid_r || s2_load;

  assign out_ch.valid          = s2_valid_r;
  assign out_ch.out_char       = s2_burst_r.ent[s2_ptr_r].ch;
  assign out_ch.end_of_message = s2_burst_r.ent[s2_ptr_r].eom;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s2_ptr_r   <= 2'd0;
      st_r       <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s1_valid_r <= 1'b1;
      end else if (s2_load) begin
        s1_valid_r <= 1'b0;
      end

      if (s2_load) begin
        s2_valid_r <= 1'b1;
        s2_ptr_r   <= 2'd0;
        st_r       <= st_nxt;
      end else if (s2_done) begin
        s2_valid_r <= 1'b0;
      end else if (out_take) begin
        s2_ptr_r <= s2_ptr_r + 2'd1;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.data_byte;
      s1_fin_r  <= in_ch.is_final;
    end
    if (s2_load) begin
      s2_burst_r <= burst_nxt;
    end
  end

  // The read pointer never runs past the last character of the burst.
  assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (s2_ptr_r <= s2_burst_r.last))
    else $error("burst read pointer beyond last character");

  // The end marker only appears on the last character of a burst.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_burst_r.ent[s2_ptr_r].eom) |-> (s2_ptr_r == s2_burst_r.last))
    else $error("end of message flagged before end of burst");

  // Loading the final byte of a message returns the encoder state to reset.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s2_load && s1_fin_r) |=> (st_r == '0))
    else $error("encoder state not cleared after final byte");

  // Leftover count and group position stay within their ranges.
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.cnt <= 3'd4) && (st_r.grp <= GROUP_LAST))
    else $error("encoder state out of range");

  // A byte waiting in the input register is held until the burst register takes it.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_load) |=> (s1_valid_r && $stable(s1_byte_r)))
    else $error("pending byte lost");

endmodule

// File: rtl/b32e_expand.sv
`timescale 1ns / 1ps

module b32e_expand
  import b32e_pkg::*;
(
  input  b32e_state_t state_i,
  input  logic [7:0]  byte_i,
  input  logic        fin_i,
  output b32e_burst_t burst_o,
  output b32e_state_t state_o
);

  logic [11:0] acc;
  logic [3:0]  total;
  logic        two;
  logic [2:0]  rem;
  logic        flush;
  logic [3:0]  low_bits;
  logic [8:0]  flush_wide;
  logic [4:0]  sym0;
  logic [4:0]  sym1;
  logic [4:0]  fsym;

  assign acc        = {state_i.bits, byte_i};
  assign total      = {1'b0, state_i.cnt} + 4'd8;
  assign two        = (total >= 4'd10);
  assign sym0       = 5'(acc >> (total - SYM_BITS));
  assign sym1       = 5'(acc >> (total - 4'd10));
  assign rem        = two ? 3'(total - 4'd10) : 3'(total - SYM_BITS);
  assign flush      = fin_i && (rem != 3'd0);
  assign low_bits   = acc[3:0] & 4'((5'd1 << rem) - 5'd1);
  assign flush_wide = {5'd0, low_bits} << (3'd5 - rem);
  assign fsym       = flush_wide[4:0];

  always_comb begin
    logic [4:0] syms [3];
    logic [1:0] nsym;
    logic [2:0] n;
    logic [2:0] gp;
    logic       any;
    syms[0] = sym0;
    syms[1] = two ? sym1 : fsym;
    syms[2] = fsym;
    nsym    = 2'd1 + {1'b0, two} + {1'b0, flush};
    n       = 3'd0;
    gp      = state_i.grp;
    any     = state_i.any;
    burst_o = '0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < nsym) begin
        if (any && gp == 3'd0) begin
          burst_o.ent[n[1:0]] = '{ch: DASH_CHAR, eom: 1'b0};
          n = n + 3'd1;
        end
        burst_o.ent[n[1:0]] = '{ch: sym_ascii(syms[i]), eom: 1'b0};
        n   = n + 3'd1;
        any = 1'b1;
        gp  = (gp == GROUP_LAST) ? 3'd0 : gp + 3'd1;
      end
    end
    burst_o.last = 2'(n - 3'd1);
    if (fin_i) begin
      burst_o.ent[burst_o.last].eom = 1'b1;
      state_o = '0;
    end else begin
      state_o = '{bits: low_bits, cnt: rem, grp: gp, any: any};
    end
  end

endmodule
